/* rtl/hid_pkg.sv */
`timescale 1ns / 1ps

package hid_pkg;

  // Field widths
  localparam int DATA_W     = 32;
  localparam int LAYOUT_W   = 4;
  localparam int STATUS_W   = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_W      = DATA_W;

  // Index bits that are significant; the rest of linear_index is dropped
  localparam int INDEX_BITS = 32;
  localparam logic [DATA_W-1:0] INDEX_MASK =
    DATA_W'((65'd1 << INDEX_BITS) - 65'd1);

  // One restoring step per stage in each divider
  localparam int DIV_STAGES = DATA_W;

  // Configuration register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LAYOUT     = 3'd0,
    REG_LON_START  = 3'd1,
    REG_LON_LENGTH = 3'd2,
    REG_LAT_START  = 3'd3,
    REG_LAT_LENGTH = 3'd4,
    REG_LEV_START  = 3'd5,
    REG_LEV_LENGTH = 3'd6
  } cfg_reg_e;

  // Storage orders, outermost dimension first
  typedef enum logic [LAYOUT_W-1:0] {
    LAYOUT_LON_LAT     = 4'd0,
    LAYOUT_LAT_LON     = 4'd1,
    LAYOUT_LAT_LEV     = 4'd2,
    LAYOUT_LEV_LAT     = 4'd3,
    LAYOUT_LON_LEV     = 4'd4,
    LAYOUT_LEV_LON     = 4'd5,
    LAYOUT_LON_LAT_LEV = 4'd6,
    LAYOUT_LEV_LON_LAT = 4'd7,
    LAYOUT_LON_LEV_LAT = 4'd8,
    LAYOUT_LEV_LAT_LON = 4'd9,
    LAYOUT_LAT_LEV_LON = 4'd10,
    LAYOUT_LAT_LON_LEV = 4'd11
  } layout_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_LAYOUT  = 2'd1,
    STATUS_ZERO_LENGTH = 2'd2,
    STATUS_OVERFLOW    = 2'd3
  } status_e;

  // Which quotient/remainder feeds a dimension's offset
  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_OUTER = 2'd1,
    SRC_MID   = 2'd2,
    SRC_INNER = 2'd3
  } src_e;

  // Per-item context carried alongside the dividers
  typedef struct packed {
    logic              bad_layout;
    logic              zero_length;
    logic              three;
    src_e              src_lon;
    src_e              src_lat;
    src_e              src_lev;
    logic [DATA_W-1:0] mid_length;
    logic [DATA_W-1:0] inner_rem;
    logic [DATA_W-1:0] lon_base;
    logic [DATA_W-1:0] lat_base;
    logic [DATA_W-1:0] lev_base;
  } ctx_t;

endpackage

/* rtl/hid_front.sv */
`timescale 1ns / 1ps

module hid_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [hid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [hid_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              en,
  input  logic                              index_valid,
  input  logic [hid_pkg::DATA_W-1:0]        linear_index,
  output logic                              dec_valid,
  output logic [hid_pkg::DATA_W-1:0]        dec_dividend,
  output logic [hid_pkg::DATA_W-1:0]        dec_divisor,
  output hid_pkg::ctx_t                     dec_ctx
);

  logic [hid_pkg::LAYOUT_W-1:0] layout;
  logic [hid_pkg::DATA_W-1:0]   lon_base, lon_size;
  logic [hid_pkg::DATA_W-1:0]   lat_base, lat_size;
  logic [hid_pkg::DATA_W-1:0]   lev_base, lev_size;

  logic                         bad, three, zero;
  hid_pkg::src_e                src_lon, src_lat, src_lev;
  logic [hid_pkg::DATA_W-1:0]   inner_len, mid_len;
  logic [hid_pkg::DATA_W-1:0]   inner_safe, mid_safe;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layout   <= hid_pkg::LAYOUT_W'(hid_pkg::LAYOUT_LON_LAT);
      lon_base <= '0;
      lon_size <= hid_pkg::DATA_W'(1);
      lat_base <= '0;
      lat_size <= hid_pkg::DATA_W'(1);
      lev_base <= '0;
      lev_size <= hid_pkg::DATA_W'(1);
    end else if (cfg_write) begin
      case (cfg_addr)
        hid_pkg::REG_LAYOUT:     layout   <= cfg_data[hid_pkg::LAYOUT_W-1:0];
        hid_pkg::REG_LON_START:  lon_base <= cfg_data;
        hid_pkg::REG_LON_LENGTH: lon_size <= cfg_data;
        hid_pkg::REG_LAT_START:  lat_base <= cfg_data;
        hid_pkg::REG_LAT_LENGTH: lat_size <= cfg_data;
        hid_pkg::REG_LEV_START:  lev_base <= cfg_data;
        hid_pkg::REG_LEV_LENGTH: lev_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Layout decode: role of each dimension
  always_comb begin
    bad     = 1'b0;
    three   = 1'b0;
    src_lon = hid_pkg::SRC_NONE;
    src_lat = hid_pkg::SRC_NONE;
    src_lev = hid_pkg::SRC_NONE;
    case (layout)
      hid_pkg::LAYOUT_LON_LAT: begin
        src_lon = hid_pkg::SRC_OUTER; src_lat = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LAT_LON: begin
        src_lat = hid_pkg::SRC_OUTER; src_lon = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LAT_LEV: begin
        src_lat = hid_pkg::SRC_OUTER; src_lev = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LEV_LAT: begin
        src_lev = hid_pkg::SRC_OUTER; src_lat = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LON_LEV: begin
        src_lon = hid_pkg::SRC_OUTER; src_lev = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LEV_LON: begin
        src_lev = hid_pkg::SRC_OUTER; src_lon = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LON_LAT_LEV: begin
        three = 1'b1;
        src_lon = hid_pkg::SRC_OUTER; src_lat = hid_pkg::SRC_MID;
        src_lev = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LEV_LON_LAT: begin
        three = 1'b1;
        src_lev = hid_pkg::SRC_OUTER; src_lon = hid_pkg::SRC_MID;
        src_lat = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LON_LEV_LAT: begin
        three = 1'b1;
        src_lon = hid_pkg::SRC_OUTER; src_lev = hid_pkg::SRC_MID;
        src_lat = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LEV_LAT_LON: begin
        three = 1'b1;
        src_lev = hid_pkg::SRC_OUTER; src_lat = hid_pkg::SRC_MID;
        src_lon = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LAT_LEV_LON: begin
        three = 1'b1;
        src_lat = hid_pkg::SRC_OUTER; src_lev = hid_pkg::SRC_MID;
        src_lon = hid_pkg::SRC_INNER;
      end
      hid_pkg::LAYOUT_LAT_LON_LEV: begin
        three = 1'b1;
        src_lat = hid_pkg::SRC_OUTER; src_lon = hid_pkg::SRC_MID;
        src_lev = hid_pkg::SRC_INNER;
      end
      default: bad = 1'b1;
    endcase
  end

  // Divisor lengths; 2-D pairs divide by one in the second divider
  always_comb begin
    if (src_lon == hid_pkg::SRC_INNER)      inner_len = lon_size;
    else if (src_lat == hid_pkg::SRC_INNER) inner_len = lat_size;
    else                                    inner_len = lev_size;

    if (!three)                             mid_len = hid_pkg::DATA_W'(1);
    else if (src_lon == hid_pkg::SRC_MID)   mid_len = lon_size;
    else if (src_lat == hid_pkg::SRC_MID)   mid_len = lat_size;
    else                                    mid_len = lev_size;

    zero       = !bad && ((inner_len == '0) || (mid_len == '0));
    inner_safe = (bad || zero) ? hid_pkg::DATA_W'(1) : inner_len;
    mid_safe   = (bad || zero) ? hid_pkg::DATA_W'(1) : mid_len;
  end

  // Input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (en) begin
      dec_valid <= index_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_dividend           <= linear_index & hid_pkg::INDEX_MASK;
      dec_divisor            <= inner_safe;
      dec_ctx.bad_layout     <= bad;
      dec_ctx.zero_length    <= zero;
      dec_ctx.three          <= three;
      dec_ctx.src_lon        <= src_lon;
      dec_ctx.src_lat        <= src_lat;
      dec_ctx.src_lev        <= src_lev;
      dec_ctx.mid_length     <= mid_safe;
      dec_ctx.inner_rem      <= '0;
      dec_ctx.lon_base       <= lon_base;
      dec_ctx.lat_base       <= lat_base;
      dec_ctx.lev_base       <= lev_base;
    end
  end

endmodule

/* rtl/hid_divider.sv */
`timescale 1ns / 1ps

module hid_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [hid_pkg::DATA_W-1:0]    in_dividend,
  input  logic [hid_pkg::DATA_W-1:0]    in_divisor,
  input  hid_pkg::ctx_t                 in_ctx,
  output logic                          out_valid,
  output logic [hid_pkg::DATA_W-1:0]    out_quotient,
  output logic [hid_pkg::DATA_W-1:0]    out_remainder,
  output hid_pkg::ctx_t                 out_ctx
);

  localparam int N = hid_pkg::DIV_STAGES;
  localparam int W = hid_pkg::DATA_W;

  // Stage registers; dvd shifts the dividend out and the quotient in
  logic          vld_q [0:N-1];
  logic [W-1:0]  rem_q [0:N-1];
  logic [W-1:0]  dvd_q [0:N-1];
  logic [W-1:0]  dsr_q [0:N-1];
  hid_pkg::ctx_t ctx_q [0:N-1];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic          vld_i;
    logic [W-1:0]  rem_i, dvd_i, dsr_i;
    hid_pkg::ctx_t ctx_i;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_i = in_valid;
      assign rem_i = '0;
      assign dvd_i = in_dividend;
      assign dsr_i = in_divisor;
      assign ctx_i = in_ctx;
    end else begin : g_chain
      assign vld_i = vld_q[s-1];
      assign rem_i = rem_q[s-1];
      assign dvd_i = dvd_q[s-1];
      assign dsr_i = dsr_q[s-1];
      assign ctx_i = ctx_q[s-1];
    end

    // One restoring step: bring down a dividend bit, subtract if it fits
    assign trial = {rem_i, dvd_i[W-1]};
    assign diff  = trial - {1'b0, dsr_i};
    assign ge    = !diff[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? diff[W-1:0] : trial[W-1:0];
        dvd_q[s] <= {dvd_i[W-2:0], ge};
        dsr_q[s] <= dsr_i;
        ctx_q[s] <= ctx_i;
      end
    end
  end

  assign out_valid     = vld_q[N-1];
  assign out_quotient  = dvd_q[N-1];
  assign out_remainder = rem_q[N-1];
  assign out_ctx       = ctx_q[N-1];

`ifndef NO_ASSERTIONS
  // A finished remainder is always below its divisor
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    vld_q[N-1] |-> (rem_q[N-1] < dsr_q[N-1]))
    else $error("divider remainder not below divisor");
`endif

endmodule

/* rtl/hid_output.sv */
`timescale 1ns / 1ps

module hid_output (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [hid_pkg::DATA_W-1:0]      in_outer,
  input  logic [hid_pkg::DATA_W-1:0]      in_mid,
  input  hid_pkg::ctx_t                   in_ctx,
  input  logic                            stall,
  output logic                            advance,
  output logic                            out_valid,
  output logic [hid_pkg::DATA_W-1:0]      out_first,
  output logic [hid_pkg::DATA_W-1:0]      out_second,
  output logic [hid_pkg::DATA_W-1:0]      out_third,
  output logic [hid_pkg::STATUS_W-1:0]    out_status
);

  localparam int W = hid_pkg::DATA_W;

  logic [W-1:0]    off_lon, off_lat, off_lev;
  logic [W:0]      sum_lon, sum_lat, sum_lev;
  logic            ovf;
  logic [W-1:0]    res_first, res_second, res_third;
  hid_pkg::status_e res_status;

  logic            skid_valid;
  logic [W-1:0]    skid_first, skid_second, skid_third;
  hid_pkg::status_e skid_status;
  hid_pkg::status_e status_q;
  logic            take;

  function automatic logic [W-1:0] pick(hid_pkg::src_e src, logic [W-1:0] outer,
                                        logic [W-1:0] mid, logic [W-1:0] inner);
    logic [W-1:0] r;
    case (src)
      hid_pkg::SRC_OUTER: r = outer;
      hid_pkg::SRC_MID:   r = mid;
      hid_pkg::SRC_INNER: r = inner;
      default:            r = '0;
    endcase
    return r;
  endfunction

  // Offsets per dimension, add starts, check carry-out on used dimensions
  always_comb begin
    off_lon = pick(in_ctx.src_lon, in_outer, in_mid, in_ctx.inner_rem);
    off_lat = pick(in_ctx.src_lat, in_outer, in_mid, in_ctx.inner_rem);
    off_lev = pick(in_ctx.src_lev, in_outer, in_mid, in_ctx.inner_rem);
    sum_lon = {1'b0, in_ctx.lon_base} + {1'b0, off_lon};
    sum_lat = {1'b0, in_ctx.lat_base} + {1'b0, off_lat};
    sum_lev = {1'b0, in_ctx.lev_base} + {1'b0, off_lev};
    ovf = ((in_ctx.src_lon != hid_pkg::SRC_NONE) && sum_lon[W])
       || ((in_ctx.src_lat != hid_pkg::SRC_NONE) && sum_lat[W])
       || ((in_ctx.src_lev != hid_pkg::SRC_NONE) && sum_lev[W]);
  end

  // Canonical order lon, lat, lev; a pair fills the first two fields
  always_comb begin
    if (in_ctx.bad_layout || in_ctx.zero_length) begin
      res_first  = '0;
      res_second = '0;
      res_third  = '0;
      res_status = in_ctx.bad_layout ? hid_pkg::STATUS_BAD_LAYOUT
                                     : hid_pkg::STATUS_ZERO_LENGTH;
    end else begin
      res_first  = (in_ctx.src_lon != hid_pkg::SRC_NONE) ? sum_lon[W-1:0]
                                                         : sum_lat[W-1:0];
      res_second = (in_ctx.three || (in_ctx.src_lev == hid_pkg::SRC_NONE))
                   ? sum_lat[W-1:0] : sum_lev[W-1:0];
      res_third  = in_ctx.three ? sum_lev[W-1:0] : '0;
      res_status = ovf ? hid_pkg::STATUS_OVERFLOW : hid_pkg::STATUS_OK;
    end
  end

  // Output register plus skid; the pipeline moves while the skid is empty
  assign take    = out_valid && !stall;
  assign advance = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_first  <= skid_first;
        out_second <= skid_second;
        out_third  <= skid_third;
        status_q   <= skid_status;
      end
    end else if (in_valid) begin
      if (out_valid && !take) begin
        skid_first  <= res_first;
        skid_second <= res_second;
        skid_third  <= res_third;
        skid_status <= res_status;
      end else begin
        out_first  <= res_first;
        out_second <= res_second;
        out_third  <= res_third;
        status_q   <= res_status;
      end
    end
  end

  assign out_status = status_q;

`ifndef NO_ASSERTIONS
  // Skid only holds an item behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds item while output empty");

  // Skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && stall))
    else $error("skid filled without output stall");

  // Bad layout results carry zero coordinates
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status_q == hid_pkg::STATUS_BAD_LAYOUT))
      |-> ((out_first == '0) && (out_second == '0) && (out_third == '0)))
    else $error("bad layout result has nonzero coordinates");
`endif

endmodule

/* rtl/hyperslab_index_delinearizer.sv */
`timescale 1ns / 1ps
// Pipeline from index accept to result valid: input register, 32-stage divider by the
//   inner length, 32-stage divider by the middle length, output register; the two
//   restoring dividers set the depth.
// Throughput: one item per cycle; index_stall rises only once the output skid holds.
// Reset: config goes to layout Lon_Lat, starts 0, lengths 1; pipeline empties.

module hyperslab_index_delinearizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [hid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [hid_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              index_valid,
  output logic                              index_stall,
  input  logic [hid_pkg::DATA_W-1:0]        linear_index,
  output logic                              coord_valid,
  input  logic                              coord_stall,
  output logic [hid_pkg::DATA_W-1:0]        first_coord,
  output logic [hid_pkg::DATA_W-1:0]        second_coord,
  output logic [hid_pkg::DATA_W-1:0]        third_coord,
  output logic [hid_pkg::STATUS_W-1:0]      status
);

  logic                       en;
  logic                       dec_valid;
  logic [hid_pkg::DATA_W-1:0] dec_dividend, dec_divisor;
  hid_pkg::ctx_t              dec_ctx;

  logic                       d1_valid;
  logic [hid_pkg::DATA_W-1:0] d1_quot, d1_rem;
  hid_pkg::ctx_t              d1_ctx, d2_in_ctx;

  logic                       d2_valid;
  logic [hid_pkg::DATA_W-1:0] d2_quot, d2_rem;
  hid_pkg::ctx_t              d2_ctx;

  assign index_stall = !en;

  // Config registers, layout decode, input register
  hid_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .en           (en),
    .index_valid  (index_valid),
    .linear_index (linear_index),
    .dec_valid    (dec_valid),
    .dec_dividend (dec_dividend),
    .dec_divisor  (dec_divisor),
    .dec_ctx      (dec_ctx)
  );

  // Index / inner length
  hid_divider u_div_inner (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (dec_valid),
    .in_dividend   (dec_dividend),
    .in_divisor    (dec_divisor),
    .in_ctx        (dec_ctx),
    .out_valid     (d1_valid),
    .out_quotient  (d1_quot),
    .out_remainder (d1_rem),
    .out_ctx       (d1_ctx)
  );

  // Inner remainder rides along as the innermost offset
  always_comb begin
    d2_in_ctx           = d1_ctx;
    d2_in_ctx.inner_rem = d1_rem;
  end

  // First quotient / middle length (one for pairs)
  hid_divider u_div_mid (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (d1_valid),
    .in_dividend   (d1_quot),
    .in_divisor    (d1_ctx.mid_length),
    .in_ctx        (d2_in_ctx),
    .out_valid     (d2_valid),
    .out_quotient  (d2_quot),
    .out_remainder (d2_rem),
    .out_ctx       (d2_ctx)
  );

  // Start addition, status, output register and skid
  hid_output u_output (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d2_valid),
    .in_outer   (d2_quot),
    .in_mid     (d2_rem),
    .in_ctx     (d2_ctx),
    .stall      (coord_stall),
    .advance    (en),
    .out_valid  (coord_valid),
    .out_first  (first_coord),
    .out_second (second_coord),
    .out_third  (third_coord),
    .out_status (status)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import hid_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 20;
  localparam int PHASE_ITEMS   = 23;
  localparam int DRAIN_CYCLES  = 100;

  // Dimension codes used to index the start/length copies
  typedef enum int {
    DIM_LON = 0,
    DIM_LAT = 1,
    DIM_LEV = 2
  } dim_e;

  typedef struct packed {
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] second;
    logic [DATA_W-1:0] third;
    status_e           st;
  } coord_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  index_valid = 1'b0;
  logic                  index_stall;
  logic [DATA_W-1:0]     linear_index = '0;
  logic                  coord_valid;
  logic                  coord_stall = 1'b0;
  logic [DATA_W-1:0]     first_coord;
  logic [DATA_W-1:0]     second_coord;
  logic [DATA_W-1:0]     third_coord;
  logic [STATUS_W-1:0]   status;

  hyperslab_index_delinearizer uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .index_valid  (index_valid),
    .index_stall  (index_stall),
    .linear_index (linear_index),
    .coord_valid  (coord_valid),
    .coord_stall  (coord_stall),
    .first_coord  (first_coord),
    .second_coord (second_coord),
    .third_coord  (third_coord),
    .status       (status)
  );

  // Shadow copy of the block's registers
  logic [LAYOUT_W-1:0] cfg_layout;
  logic [DATA_W-1:0]   dim_start [3];
  logic [DATA_W-1:0]   dim_length [3];

  logic [DATA_W-1:0] pending_index [$];
  coord_t            expected_coords [$];

  int fail_count  = 0;
  int cycle_count = 0;
  int send_gap    = 0;
  int send_calm   = 0;
  int recv_wait   = 0;
  int recv_calm   = 0;
  coord_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Outermost-first dimension order of a storage layout
  function automatic void layout_dims(input logic [LAYOUT_W-1:0] lay,
                                      output int o0, output int o1, output int o2);
    o0 = DIM_LON;
    o1 = DIM_LAT;
    o2 = DIM_LON;
    case (layout_e'(lay))
      LAYOUT_LON_LAT:     begin o0 = DIM_LON; o1 = DIM_LAT; end
      LAYOUT_LAT_LON:     begin o0 = DIM_LAT; o1 = DIM_LON; end
      LAYOUT_LAT_LEV:     begin o0 = DIM_LAT; o1 = DIM_LEV; end
      LAYOUT_LEV_LAT:     begin o0 = DIM_LEV; o1 = DIM_LAT; end
      LAYOUT_LON_LEV:     begin o0 = DIM_LON; o1 = DIM_LEV; end
      LAYOUT_LEV_LON:     begin o0 = DIM_LEV; o1 = DIM_LON; end
      LAYOUT_LON_LAT_LEV: begin o0 = DIM_LON; o1 = DIM_LAT; o2 = DIM_LEV; end
      LAYOUT_LEV_LON_LAT: begin o0 = DIM_LEV; o1 = DIM_LON; o2 = DIM_LAT; end
      LAYOUT_LON_LEV_LAT: begin o0 = DIM_LON; o1 = DIM_LEV; o2 = DIM_LAT; end
      LAYOUT_LEV_LAT_LON: begin o0 = DIM_LEV; o1 = DIM_LAT; o2 = DIM_LON; end
      LAYOUT_LAT_LEV_LON: begin o0 = DIM_LAT; o1 = DIM_LEV; o2 = DIM_LON; end
      LAYOUT_LAT_LON_LEV: begin o0 = DIM_LAT; o1 = DIM_LON; o2 = DIM_LEV; end
      default: ;
    endcase
  endfunction

  // Coordinates expected for one index under the current registers
  function automatic coord_t predict_coords(input logic [DATA_W-1:0] raw);
    logic [63:0] idx;
    logic [63:0] li;
    logic [63:0] lm;
    logic [63:0] prod;
    logic [63:0] rem;
    logic [63:0] off [3];
    logic [63:0] sum [3];
    logic        used [3];
    int          o0;
    int          o1;
    int          o2;
    int          lo;
    int          hi;
    coord_t      r;
    r = '0;
    r.st = STATUS_OK;
    idx = {32'd0, raw & INDEX_MASK};
    for (int d = 0; d < 3; d++) begin
      off[d] = '0;
      used[d] = 1'b0;
    end
    if (cfg_layout > LAYOUT_LAT_LON_LEV) begin
      r.st = STATUS_BAD_LAYOUT;
      return r;
    end
    layout_dims(cfg_layout, o0, o1, o2);
    if (cfg_layout < LAYOUT_LON_LAT_LEV) begin
      li = {32'd0, dim_length[o1]};
      if (li == 0) begin
        r.st = STATUS_ZERO_LENGTH;
        return r;
      end
      off[o0] = idx / li;
      off[o1] = idx % li;
      used[o0] = 1'b1;
      used[o1] = 1'b1;
    end else begin
      lm = {32'd0, dim_length[o1]};
      li = {32'd0, dim_length[o2]};
      if (lm == 0 || li == 0) begin
        r.st = STATUS_ZERO_LENGTH;
        return r;
      end
      prod = lm * li;
      rem = idx % prod;
      off[o0] = idx / prod;
      off[o1] = rem / li;
      off[o2] = rem % li;
      used[0] = 1'b1;
      used[1] = 1'b1;
      used[2] = 1'b1;
    end
    for (int d = 0; d < 3; d++) begin
      sum[d] = {32'd0, dim_start[d]} + off[d];
      if (used[d] && sum[d][63:32] != 0)
        r.st = STATUS_OVERFLOW;
    end
    if (cfg_layout >= LAYOUT_LON_LAT_LEV) begin
      r.first  = sum[0][31:0];
      r.second = sum[1][31:0];
      r.third  = sum[2][31:0];
    end else begin
      // pair comes out in canonical lon, lat, lev order
      lo = (o0 < o1) ? o0 : o1;
      hi = (o0 < o1) ? o1 : o0;
      r.first  = sum[lo][31:0];
      r.second = sum[hi][31:0];
    end
    return r;
  endfunction

  // Per-item wait draw, with occasional stretches of no waiting
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                             input logic [DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Index driver: feeds pending items, predicts at acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (index_valid && !index_stall)
        expected_coords.push_back(predict_coords(linear_index));
      if (!index_valid || !index_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          index_valid <= 1'b0;
        end else if (pending_index.size() > 0) begin
          linear_index <= pending_index.pop_front();
          index_valid  <= 1'b1;
          send_gap = draw_wait(send_calm);
        end else begin
          index_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (coord_valid && !coord_stall) begin
        if (expected_coords.size() == 0) begin
          $display("%0t: unexpected result, actual %h %h %h status %0d", $time,
                   first_coord, second_coord, third_coord, status);
          fail_count++;
        end else begin
          want = expected_coords.pop_front();
          check_field("first_coord", want.first, first_coord);
          check_field("second_coord", want.second, second_coord);
          check_field("third_coord", want.third, third_coord);
          check_field("status", DATA_W'(want.st), DATA_W'(status));
        end
        recv_wait = draw_wait(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        coord_stall <= 1'b1;
      end else begin
        coord_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_index.size() != 0 || index_valid || expected_coords.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_addr  <= r;
    cfg_data  <= v;
    case (r)
      REG_LAYOUT:     cfg_layout = v[LAYOUT_W-1:0];
      REG_LON_START:  dim_start[DIM_LON] = v;
      REG_LON_LENGTH: dim_length[DIM_LON] = v;
      REG_LAT_START:  dim_start[DIM_LAT] = v;
      REG_LAT_LENGTH: dim_length[DIM_LAT] = v;
      REG_LEV_START:  dim_start[DIM_LEV] = v;
      REG_LEV_LENGTH: dim_length[DIM_LEV] = v;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] lay,
                          input logic [CFG_W-1:0] lon_s, input logic [CFG_W-1:0] lon_l,
                          input logic [CFG_W-1:0] lat_s, input logic [CFG_W-1:0] lat_l,
                          input logic [CFG_W-1:0] lev_s, input logic [CFG_W-1:0] lev_l);
    wait_idle();
    write_reg(REG_LAYOUT, lay);
    write_reg(REG_LON_START, lon_s);
    write_reg(REG_LON_LENGTH, lon_l);
    write_reg(REG_LAT_START, lat_s);
    write_reg(REG_LAT_LENGTH, lat_l);
    write_reg(REG_LEV_START, lev_s);
    write_reg(REG_LEV_LENGTH, lev_l);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom;
      4, 5:    return $urandom_range(1, 7);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_start();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 50);
      3:       return $urandom;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // One phase of random registers and indices, mostly inside the hyperslab
  task automatic random_phase(input logic [LAYOUT_W-1:0] lay, input int n);
    logic [127:0] vol;
    logic [63:0]  span;
    int           o0;
    int           o1;
    int           o2;
    set_regs(lay, rand_start(), rand_length(), rand_start(), rand_length(),
             rand_start(), rand_length());
    layout_dims(cfg_layout, o0, o1, o2);
    if (cfg_layout > LAYOUT_LAT_LON_LEV)
      vol = '0;
    else if (cfg_layout < LAYOUT_LON_LAT_LEV)
      vol = 128'(dim_length[o0]) * 128'(dim_length[o1]);
    else
      vol = 128'(dim_length[o0]) * 128'(dim_length[o1]) * 128'(dim_length[o2]);
    span = (vol > 128'h1_0000_0000) ? 64'h1_0000_0000 : vol[63:0];
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: pending_index.push_back($urandom);
        1: pending_index.push_back($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0);
        default: begin
          if (span == 0)
            pending_index.push_back($urandom);
          else
            pending_index.push_back(DATA_W'({$urandom, $urandom} % span));
        end
      endcase
    end
  endtask

  // Stimulus sequence
  initial begin
    cfg_layout = LAYOUT_LON_LAT;
    for (int d = 0; d < 3; d++) begin
      dim_start[d]  = '0;
      dim_length[d] = 32'd1;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset registers
    pending_index.push_back(32'd0);
    pending_index.push_back(32'hFFFF_FFFF);
    pending_index.push_back(32'd12345);

    // Lev_Lon takes the level start for the level offset
    set_regs(LAYOUT_LEV_LON, 32'd10, 32'd5, 32'd1000, 32'd3, 32'd20, 32'd4);
    pending_index.push_back(32'd13);
    pending_index.push_back(32'd0);

    // 3-D, including an outer offset past its length
    set_regs(LAYOUT_LAT_LON_LEV, 32'd1, 32'd3, 32'd2, 32'd4, 32'd3, 32'd5);
    pending_index.push_back(32'd0);
    pending_index.push_back(32'd59);
    pending_index.push_back(32'd60);
    pending_index.push_back(32'hFFFF_FFFF);

    // overflow on inner and outer sums; unused level start ignored
    set_regs(LAYOUT_LON_LAT, 32'hFFFF_FFFF, 32'd9, 32'hFFFF_FFF0, 32'd32,
             32'hFFFF_FFFF, 32'd0);
    pending_index.push_back(32'd0);
    pending_index.push_back(32'd16);
    pending_index.push_back(32'd32);

    // zero middle length
    set_regs(LAYOUT_LON_LEV_LAT, 32'd0, 32'd4, 32'd0, 32'd6, 32'd0, 32'd0);
    pending_index.push_back(32'd5);

    // zero outer length is not checked
    set_regs(LAYOUT_LAT_LEV, 32'd0, 32'd0, 32'd7, 32'd0, 32'd3, 32'd7);
    pending_index.push_back(32'd100);

    // invalid layouts
    set_regs(32'd12, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    pending_index.push_back(32'd3);
    set_regs(32'd15, 32'd0, 32'd2, 32'd0, 32'd2, 32'd0, 32'd2);
    pending_index.push_back(32'hFFFF_FFFF);

    // largest lengths
    set_regs(LAYOUT_LEV_LAT_LON, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
             32'd0, 32'hFFFF_FFFF);
    pending_index.push_back(32'hFFFF_FFFF);
    pending_index.push_back(32'hFFFF_FFFE);

    // random part: every layout code once, then random layouts
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 16)
        random_phase(LAYOUT_W'(p), PHASE_ITEMS);
      else if ($urandom_range(0, 7) == 0)
        random_phase(LAYOUT_W'($urandom_range(12, 15)), PHASE_ITEMS);
      else
        random_phase(LAYOUT_W'($urandom_range(0, 11)), PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_coords.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
